>>> hdl/rbpc_pkg.sv
// Shared types, constants and the arctangent table of the rotated box corner block.
`default_nettype none

package rbpc_pkg;

  // Configuration port shape
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BOX_WIDTH   = 3'd0,
    REG_BOX_HEIGHT  = 3'd1,
    REG_START_X     = 3'd2,
    REG_START_Y     = 3'd3,
    REG_START_ANGLE = 3'd4
  } cfg_reg_t;

  // Angle units: 1/64 degree
  localparam int ANGLE_FULL    = 360 * 64;
  localparam int ANGLE_HALF    = 180 * 64;
  localparam int ANGLE_QUARTER = ANGLE_FULL / 4;
  localparam int ANGLE_THREE_Q = ANGLE_FULL - ANGLE_QUARTER;

  // Pose limits in 1/16 pixel
  localparam logic signed [16:0] POS_MIN = 17'sh10000;
  localparam logic signed [16:0] POS_MAX = 17'sh0FFFF;

  // Rotator: 16 steps, angle in 2^-14 degree
  localparam int CORDIC_STEPS    = 16;
  localparam int STEP_W          = 4;
  localparam int ZW              = 24;
  localparam int CORDIC_GAIN_Q30 = 652032874;
  localparam int ANGLE_TO_Z_SH   = 8;

  // Product selection for the four trig by half-size products
  typedef enum logic [1:0] {
    PROD_C_HW = 2'd0,
    PROD_S_HH = 2'd1,
    PROD_S_HW = 2'd2,
    PROD_C_HH = 2'd3
  } prod_sel_t;

  // Corner sign patterns: a set bit means the term is subtracted, except the y width term, which is then added
  localparam logic [3:0] CORNER_SW_NEG = 4'b1001;
  localparam logic [3:0] CORNER_SH_NEG = 4'b1100;
  localparam logic [1:0] CORNER_LAST   = 2'd3;

  // Request from the sequencer to the rotator
  typedef struct packed {
    logic                 start;
    logic signed [ZW-1:0] z;
  } rot_req_t;

  // Arctangent of 2^-i in 2^-14 degree
  function automatic logic signed [ZW-1:0] atan_lookup(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      4'd0:  r = 24'sd737280;
      4'd1:  r = 24'sd435242;
      4'd2:  r = 24'sd229970;
      4'd3:  r = 24'sd116736;
      4'd4:  r = 24'sd58595;
      4'd5:  r = 24'sd29326;
      4'd6:  r = 24'sd14667;
      4'd7:  r = 24'sd7334;
      4'd8:  r = 24'sd3667;
      4'd9:  r = 24'sd1833;
      4'd10: r = 24'sd917;
      4'd11: r = 24'sd458;
      4'd12: r = 24'sd229;
      4'd13: r = 24'sd115;
      4'd14: r = 24'sd57;
      4'd15: r = 24'sd29;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rbpc_cordic.sv
// Iterative rotation CORDIC giving cosine and sine, one shift-add step per cycle.
`default_nettype none

module rbpc_cordic #(
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rbpc_pkg::rot_req_t              req,
  output logic                            done,
  output logic signed [TRIG_FRAC_BITS+2:0] cos_q,
  output logic signed [TRIG_FRAC_BITS+2:0] sin_q
);
  import rbpc_pkg::*;

  localparam int XW = TRIG_FRAC_BITS + 3;
  localparam logic signed [XW-1:0] X0 = XW'(CORDIC_GAIN_Q30 >>> (30 - TRIG_FRAC_BITS));
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

  logic                 busy;
  logic [STEP_W-1:0]    step;
  logic signed [ZW-1:0] z;
  logic signed [XW-1:0] x_sh;
  logic signed [XW-1:0] y_sh;
  logic signed [ZW-1:0] atan_step;
  logic                 rot_pos;

  // Shared shifter and table lookup for the current step
  always_comb begin
    x_sh      = cos_q >>> step;
    y_sh      = sin_q >>> step;
    atan_step = atan_lookup(step);
    rot_pos   = !z[ZW-1];
  end

  // Load on request, then rotate towards zero residual angle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cos_q <= X0;
        sin_q <= '0;
        z     <= req.z;
        step  <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (rot_pos) begin
          cos_q <= cos_q - y_sh;
          sin_q <= sin_q + x_sh;
          z     <= z - atan_step;
        end else begin
          cos_q <= cos_q + y_sh;
          sin_q <= sin_q - x_sh;
          z     <= z + atan_step;
        end
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rotated_box_pose_corners_top.sv
// Top level of the rotated box corner block: pose update, sequencer and corner output.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in      | into      | in_valid/in_stall  | restart, dx, dy, dangle
//  out     | out of    | out_valid/out_stall| corner_index, corner_x, corner_y, last
//  cfg     | into      | cfg_write          | cfg_index, cfg_data
//
// Before its fourth corner is offered, a request passes the angle wrap (one full turn per pass),
// the shared CORDIC shift-add unit (16 steps plus hand-over), the four products on the single
// multiplier, and the sum adder and output register once per corner.
// in_stall is high from acceptance until the fourth corner is loaded into the output register.
// Output stalls hold the corner in the output register and pause the sequencer.
// Reset is synchronous: pose, configuration and control state clear, no clearing pass.
`default_nettype none

module rotated_box_pose_corners_top #(
  parameter int POS_FRAC_BITS  = 4,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              restart,
  input  logic signed [16:0]                dx,
  input  logic signed [16:0]                dy,
  input  logic signed [15:0]                dangle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        corner_index,
  output logic signed [13:0]                corner_x,
  output logic signed [13:0]                corner_y,
  output logic                              last,
  input  logic                              cfg_write,
  input  logic [rbpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rbpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rbpc_pkg::*;

  localparam int XW = TRIG_FRAC_BITS + 3;
  localparam int PW = XW + 10;
  localparam int SW = TRIG_FRAC_BITS + POS_FRAC_BITS + 20;
  localparam int QN = POS_FRAC_BITS + TRIG_FRAC_BITS;
  localparam logic signed [SW-1:0] TRUNC_BIAS = (SW'(1) <<< QN) - SW'(1);
  localparam logic signed [16:0] FULL17 = 17'(ANGLE_FULL);
  localparam logic signed [16:0] NEG_FULL17 = -17'(ANGLE_FULL);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,
    S_ROT,
    S_MUL,
    S_SUM,
    S_PUSH
  } state_t;

  state_t state;

  // Configuration registers
  logic [9:0]         box_width;
  logic [9:0]         box_height;
  logic signed [16:0] start_x;
  logic signed [16:0] start_y;
  logic [14:0]        start_angle;

  // Pose and working registers
  logic signed [16:0]    pose_x;
  logic signed [16:0]    pose_y;
  logic [14:0]           pose_angle;
  logic signed [16:0]    ang_acc;
  logic                  neg;
  logic [1:0]            mstep;
  logic [1:0]            corner;
  logic signed [PW-1:0]  prod [4];
  logic signed [SW-1:0]  sum_x;
  logic signed [SW-1:0]  sum_y;
  rot_req_t              rot_req;

  // Rotator results
  logic                  rot_done;
  logic signed [XW-1:0]  rot_cos;
  logic signed [XW-1:0]  rot_sin;

  // Combinational helpers
  logic signed [16:0] base_x;
  logic signed [16:0] base_y;
  logic [14:0]        base_a;
  logic signed [17:0] add_x;
  logic signed [17:0] add_y;
  logic signed [16:0] sat_x;
  logic signed [16:0] sat_y;
  logic signed [16:0] ang_sum;
  logic               wrap_need;
  logic signed [16:0] ang_adj;
  logic               fold_mid;
  logic               fold_hi;
  logic signed [15:0] fold_ang;
  logic signed [XW-1:0] trig_sel;
  logic signed [XW-1:0] mul_a;
  logic signed [10:0]   mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [SW-1:0] term_a;
  logic signed [SW-1:0] term_b;
  logic signed [SW-1:0] term_c;
  logic signed [SW-1:0] term_d;
  logic signed [SW-1:0] vx;
  logic signed [SW-1:0] vy;
  logic signed [SW-1:0] qx;
  logic signed [SW-1:0] qy;
  logic                 push_go;

  assign in_stall = (state != S_IDLE);

  // Load the next corner when the output register is free or being emptied
  assign push_go = (state == S_PUSH) && (!out_valid || !out_stall);

  // Write configuration registers; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      box_width   <= '0;
      box_height  <= '0;
      start_x     <= '0;
      start_y     <= '0;
      start_angle <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BOX_WIDTH:   box_width   <= cfg_data[9:0];
        REG_BOX_HEIGHT:  box_height  <= cfg_data[9:0];
        REG_START_X:     start_x     <= cfg_data[16:0];
        REG_START_Y:     start_y     <= cfg_data[16:0];
        REG_START_ANGLE: start_angle <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Translate with saturation and form the raw angle sum
  always_comb begin
    base_x  = restart ? start_x : pose_x;
    base_y  = restart ? start_y : pose_y;
    base_a  = restart ? start_angle : pose_angle;
    add_x   = {base_x[16], base_x} + {dx[16], dx};
    add_y   = {base_y[16], base_y} + {dy[16], dy};
    sat_x   = (add_x[17] != add_x[16]) ? (add_x[17] ? POS_MIN : POS_MAX) : add_x[16:0];
    sat_y   = (add_y[17] != add_y[16]) ? (add_y[17] ? POS_MIN : POS_MAX) : add_y[16:0];
    ang_sum = $signed({2'b00, base_a}) + $signed({dangle[15], dangle});
  end

  // Wrap one full turn per cycle, then fold into plus or minus a quarter turn
  always_comb begin
    wrap_need = ang_acc[16] || (ang_acc >= FULL17);
    ang_adj   = ang_acc + (ang_acc[16] ? FULL17 : NEG_FULL17);
    fold_mid  = (ang_acc[14:0] > 15'(ANGLE_QUARTER)) && (ang_acc[14:0] < 15'(ANGLE_THREE_Q));
    fold_hi   = (ang_acc[14:0] >= 15'(ANGLE_THREE_Q));
    fold_ang  = $signed({1'b0, ang_acc[14:0]})
              - (fold_mid ? 16'(ANGLE_HALF) : (fold_hi ? 16'(ANGLE_FULL) : 16'd0));
  end

  // Single multiplier: trig value times half size
  always_comb begin
    trig_sel = ((mstep == PROD_C_HW) || (mstep == PROD_C_HH)) ? rot_cos : rot_sin;
    mul_a    = neg ? -trig_sel : trig_sel;
    mul_b    = ((mstep == PROD_C_HW) || (mstep == PROD_S_HW))
             ? $signed({2'b00, box_width[9:1]}) : $signed({2'b00, box_height[9:1]});
    mul_p    = PW'(mul_a * mul_b);
  end

  // Corner sums with the sign pattern of the current corner
  always_comb begin
    term_a = SW'(prod[PROD_C_HW]) <<< POS_FRAC_BITS;
    term_b = SW'(prod[PROD_S_HH]) <<< POS_FRAC_BITS;
    term_c = SW'(prod[PROD_S_HW]) <<< POS_FRAC_BITS;
    term_d = SW'(prod[PROD_C_HH]) <<< POS_FRAC_BITS;
    vx = (SW'(pose_x) <<< TRIG_FRAC_BITS)
       + (CORNER_SW_NEG[corner] ? -term_a : term_a)
       + (CORNER_SH_NEG[corner] ? -term_b : term_b);
    vy = (SW'(pose_y) <<< TRIG_FRAC_BITS)
       + (CORNER_SW_NEG[corner] ? term_c : -term_c)
       + (CORNER_SH_NEG[corner] ? -term_d : term_d);
  end

  // Truncate toward zero to whole pixels
  always_comb begin
    qx = (sum_x + (sum_x[SW-1] ? TRUNC_BIAS : '0)) >>> QN;
    qy = (sum_y + (sum_y[SW-1] ? TRUNC_BIAS : '0)) >>> QN;
  end

  rbpc_cordic #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .req   (rot_req),
    .done  (rot_done),
    .cos_q (rot_cos),
    .sin_q (rot_sin)
  );

  // Sequencer, pose state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pose_x        <= '0;
      pose_y        <= '0;
      pose_angle    <= '0;
      out_valid     <= 1'b0;
      rot_req.start <= 1'b0;
      mstep         <= '0;
      corner        <= '0;
    end else begin
      rot_req.start <= 1'b0;
      // Raise valid on a new corner, drop it once the corner is taken
      if (push_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pose_x  <= sat_x;
            pose_y  <= sat_y;
            ang_acc <= ang_sum;
            state   <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (wrap_need) begin
            ang_acc <= ang_adj;
          end else begin
            pose_angle    <= ang_acc[14:0];
            neg           <= fold_mid;
            rot_req.start <= 1'b1;
            rot_req.z     <= ZW'(fold_ang) <<< ANGLE_TO_Z_SH;
            state         <= S_ROT;
          end
        end
        S_ROT: begin
          if (rot_done) begin
            mstep <= PROD_C_HW;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod[mstep] <= mul_p;
          mstep       <= mstep + 1'b1;
          if (mstep == PROD_C_HH) begin
            corner <= '0;
            state  <= S_SUM;
          end
        end
        S_SUM: begin
          sum_x <= vx;
          sum_y <= vy;
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (push_go) begin
            corner_index <= corner;
            corner_x     <= qx[13:0];
            corner_y     <= qy[13:0];
            last         <= (corner == CORNER_LAST);
            if (corner == CORNER_LAST) begin
              state <= S_IDLE;
            end else begin
              corner <= corner + 1'b1;
              state  <= S_SUM;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // Stored angle is always wrapped when the block is free
  ap_angle_wrapped: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (pose_angle < 15'(ANGLE_FULL)))
    else $error("pose angle left unwrapped");

  // Rotator finishes only while the sequencer waits for it
  ap_done_in_rot: assert property (@(posedge clk) disable iff (rst)
    rot_done |-> (state == S_ROT))
    else $error("rotator done outside rotate state");

  // Last mark goes with the fourth corner only
  ap_last_corner: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (corner_index == CORNER_LAST)))
    else $error("last mark on wrong corner");

  // An accepted request always starts the angle wrap
  ap_accept_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_WRAP))
    else $error("accepted request did not start");
`endif

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the rotated box corner block: table of requests, then random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbpc_pkg::*;

  localparam int POS_FRAC  = 4;
  localparam int TRIG_FRAC = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_SEGMENTS = 4;
  localparam int SEGMENT_ITEMS = 90;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int LONG_HOLD_AT = 500;

  // Register indexes past the end of the list
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = CFG_INDEX_W'(REG_START_ANGLE + 1);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = '1;

  // Arctangent of 2^-i in 2^-14 degree
  localparam longint ATAN_Q14 [CORDIC_STEPS] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29
  };

  typedef struct packed {
    logic [1:0]         idx;
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic               last;
  } corner_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_INDEX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]    reg_val;
    logic                     rs;
    logic signed [16:0]       mx;
    logic signed [16:0]       my;
    logic signed [15:0]       turn;
    bit                       typed;
    logic signed [13:0]       ex;
    logic signed [13:0]       ey;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic restart = 1'b0;
  logic signed [16:0] dx = '0;
  logic signed [16:0] dy = '0;
  logic signed [15:0] dangle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] corner_index;
  logic signed [13:0] corner_x;
  logic signed [13:0] corner_y;
  logic last;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow configuration and pose
  logic [9:0]         box_w = '0;
  logic [9:0]         box_h = '0;
  logic signed [16:0] home_x = '0;
  logic signed [16:0] home_y = '0;
  logic [14:0]        home_ang = '0;
  longint pose_x = 0;
  longint pose_y = 0;
  longint pose_ang = 0;

  corner_t   next_corners [4];
  corner_t   pending_corners [$];
  stim_row_t plan [$];
  int fault_count = 0;
  int corners_seen = 0;
  int idle_cycles = 0;

  rotated_box_pose_corners_top #(
    .POS_FRAC_BITS  (POS_FRAC),
    .TRIG_FRAC_BITS (TRIG_FRAC)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .restart      (restart),
    .dx           (dx),
    .dy           (dy),
    .dangle       (dangle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .corner_index (corner_index),
    .corner_x     (corner_x),
    .corner_y     (corner_y),
    .last         (last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return int'($urandom_range(20, 60));
    return int'($urandom_range(1, 4));
  endfunction

  function automatic logic signed [16:0] rand_shift();
    if ($urandom_range(0, 7) == 0) return 17'($urandom);
    return 17'(int'($urandom_range(0, 4000)) - 2000);
  endfunction

  function automatic logic signed [15:0] rand_turn();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 2 * ANGLE_FULL)) - ANGLE_FULL);
  endfunction

  function automatic stim_row_t item_row(bit rs, int mx, int my, int turn,
                                         bit typed, int ex, int ey);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.rs = rs;
    r.mx = 17'(mx);
    r.my = 17'(my);
    r.turn = 16'(turn);
    r.typed = typed;
    r.ex = 14'(ex);
    r.ey = 14'(ey);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx, int val);
    stim_row_t r;
    r = item_row(1'b0, 0, 0, 0, 1'b0, 0, 0);
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = CFG_DATA_W'(val);
    return r;
  endfunction

  // Shift-add rotation of the unit vector, angle folded into [-90, 90] degrees first
  function automatic void rotate_unit(input longint ang, output longint sn, output longint cs);
    longint x, y, z, nx;
    bit flip;
    flip = 1'b0;
    if (ang > ANGLE_QUARTER && ang < ANGLE_THREE_Q) begin
      ang -= ANGLE_HALF;
      flip = 1'b1;
    end else if (ang >= ANGLE_THREE_Q) begin
      ang -= ANGLE_FULL;
    end
    x = longint'(CORDIC_GAIN_Q30) >>> (30 - TRIG_FRAC);
    y = 0;
    z = ang * (longint'(1) << ANGLE_TO_Z_SH);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_Q14[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_Q14[i];
      end
      x = nx;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  // Advance the pose by one request and work out its four corners
  function automatic void predict_corners(input logic rs, input logic signed [16:0] mx,
                                          input logic signed [16:0] my,
                                          input logic signed [15:0] turn);
    longint t, sn, cs, hw, hh, bx, by, vx, vy, sw, sh;
    if (rs) begin
      pose_x = home_x;
      pose_y = home_y;
      pose_ang = home_ang;
    end
    t = pose_x + mx;
    pose_x = (t < POS_MIN) ? POS_MIN : (t > POS_MAX) ? POS_MAX : t;
    t = pose_y + my;
    pose_y = (t < POS_MIN) ? POS_MIN : (t > POS_MAX) ? POS_MAX : t;
    t = (pose_ang + turn) % ANGLE_FULL;
    pose_ang = (t < 0) ? t + ANGLE_FULL : t;
    rotate_unit(pose_ang, sn, cs);
    hw = longint'(box_w >> 1);
    hh = longint'(box_h >> 1);
    bx = pose_x * (longint'(1) << TRIG_FRAC);
    by = pose_y * (longint'(1) << TRIG_FRAC);
    for (int k = 0; k < 4; k++) begin
      sw = CORNER_SW_NEG[k] ? -1 : 1;
      sh = CORNER_SH_NEG[k] ? -1 : 1;
      vx = bx + (longint'(1) << POS_FRAC) * (sw * cs * hw + sh * sn * hh);
      vy = by + (longint'(1) << POS_FRAC) * (-sw * sn * hw + sh * cs * hh);
      // Signed division truncates toward zero
      vx = vx / (longint'(1) << (POS_FRAC + TRIG_FRAC));
      vy = vy / (longint'(1) << (POS_FRAC + TRIG_FRAC));
      next_corners[k].idx = 2'(k);
      next_corners[k].x = vx[13:0];
      next_corners[k].y = vy[13:0];
      next_corners[k].last = (2'(k) == CORNER_LAST);
    end
  endfunction

  task automatic note_fault(input string what, input corner_t want, input corner_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("%s: want idx %0d x %0d y %0d last %0d, got idx %0d x %0d y %0d last %0d",
               what, want.idx, want.x, want.y, want.last, got.idx, got.x, got.y, got.last);
  endtask

  // Offer one request, hold it until taken, then queue its corners
  task automatic issue_request(input logic rs, input logic signed [16:0] mx,
                               input logic signed [16:0] my, input logic signed [15:0] turn,
                               input bit typed, input logic signed [13:0] ex,
                               input logic signed [13:0] ey);
    corner_t c;
    in_valid <= 1'b1;
    restart <= rs;
    dx <= mx;
    dy <= my;
    dangle <= turn;
    do @(posedge clk); while (in_stall);
    predict_corners(rs, mx, my, turn);
    for (int k = 0; k < 4; k++) begin
      c = next_corners[k];
      if (typed) begin
        c.x = ex;
        c.y = ey;
      end
      pending_corners.push_back(c);
    end
  endtask

  // Drop valid for a random gap and scramble the idle payload
  task automatic pace_sender(input bit steady);
    int gap;
    if (!steady && $urandom_range(0, 2) == 0) begin
      gap = gap_len();
      in_valid <= 1'b0;
      restart <= 1'($urandom);
      dx <= 17'($urandom);
      dy <= 17'($urandom);
      dangle <= 16'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering, wait for every corner, then let the block settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_corners.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BOX_WIDTH:   box_w = val[9:0];
      REG_BOX_HEIGHT:  box_h = val[9:0];
      REG_START_X:     home_x = val[16:0];
      REG_START_Y:     home_y = val[16:0];
      REG_START_ANGLE: home_ang = val[14:0];
      default: ;
    endcase
  endtask

  // Receive corners: check against the oldest expectation, stall at random
  initial begin
    corner_t got, want;
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.idx = corner_index;
        got.x = corner_x;
        got.y = corner_y;
        got.last = last;
        corners_seen++;
        if (pending_corners.size() == 0) begin
          note_fault("unexpected corner", '0, got);
        end else begin
          want = pending_corners.pop_front();
          if (got !== want) note_fault("corner mismatch", want, got);
        end
      end
      // Hold off once for a long stretch so the input backs up
      if (!hold_done && corners_seen >= LONG_HOLD_AT) begin
        stall_left = LONG_HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (stall_left == 0 && (corners_seen / 80) % 4 != 2 &&
                   $urandom_range(0, 3) == 0) begin
        stall_left = gap_len();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus
  initial begin
    stim_row_t row;
    bit steady;
    int w, h, sa;

    // Reset settings, zero-size box: corners sit on the centre
    plan.push_back(item_row(0, 0, 0, 0, 1, 0, 0));
    plan.push_back(item_row(0, 65535, -65536, 0, 1, 4095, -4096));
    // Translation saturates at the pose limits
    plan.push_back(item_row(0, 65535, -65536, 0, 1, 4095, -4096));
    plan.push_back(item_row(1, 0, 0, 0, 1, 0, 0));
    plan.push_back(item_row(0, -65536, 65535, ANGLE_FULL, 1, -4096, 4095));
    // Truncation toward zero on negative positions
    plan.push_back(item_row(0, 1, -1, -ANGLE_FULL, 1, -4095, 4095));
    plan.push_back(item_row(1, 15, -15, -1, 1, 0, 0));
    // Largest box, extreme start pose; walk the quadrant boundaries
    plan.push_back(cfg_row(REG_BOX_WIDTH, 1023));
    plan.push_back(cfg_row(REG_BOX_HEIGHT, 1023));
    plan.push_back(cfg_row(REG_START_X, 65535));
    plan.push_back(cfg_row(REG_START_Y, -65536));
    plan.push_back(cfg_row(REG_START_ANGLE, 0));
    plan.push_back(item_row(1, 0, 0, 0, 0, 0, 0));
    plan.push_back(item_row(0, 0, 0, ANGLE_QUARTER, 0, 0, 0));
    plan.push_back(item_row(0, 0, 0, 1, 0, 0, 0));
    plan.push_back(item_row(0, 0, 0, ANGLE_QUARTER - 1, 0, 0, 0));
    plan.push_back(item_row(0, 0, 0, ANGLE_QUARTER, 0, 0, 0));
    plan.push_back(item_row(0, 0, 0, 1, 0, 0, 0));
    plan.push_back(item_row(0, 0, 0, -2, 0, 0, 0));
    plan.push_back(item_row(1, 0, 0, -1, 0, 0, 0));
    // Rotation beyond a full turn either way
    plan.push_back(item_row(0, 0, 0, 32767, 0, 0, 0));
    plan.push_back(item_row(0, 0, 0, -32768, 0, 0, 0));
    plan.push_back(item_row(0, -65536, 65535, ANGLE_FULL, 0, 0, 0));
    plan.push_back(item_row(0, -65536, 65535, 0, 0, 0, 0));
    // Start angle past a full turn, odd sizes, writes past the register list
    plan.push_back(cfg_row(REG_START_ANGLE, 32767));
    plan.push_back(cfg_row(REG_BOX_WIDTH, 1));
    plan.push_back(cfg_row(REG_BOX_HEIGHT, 3));
    plan.push_back(cfg_row(REG_START_X, -65536));
    plan.push_back(cfg_row(REG_START_Y, 65535));
    plan.push_back(cfg_row(REG_SPARE_FIRST, 17'h1FFFF));
    plan.push_back(cfg_row(REG_SPARE_LAST, 0));
    plan.push_back(item_row(1, 0, 0, 0, 0, 0, 0));
    plan.push_back(item_row(1, 0, 0, -ANGLE_FULL, 0, 0, 0));
    plan.push_back(item_row(1, 0, 0, -32768, 0, 0, 0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        wait_quiet();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        issue_request(row.rs, row.mx, row.my, row.turn, row.typed, row.ex, row.ey);
        pace_sender(1'b0);
      end
    end

    // Random traffic over several settings
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      wait_quiet();
      case (seg)
        0: begin w = int'($urandom_range(0, 64)); h = int'($urandom_range(0, 64)); end
        1: begin w = 1023; h = 0; end
        2: begin w = int'($urandom_range(0, 1023)); h = int'($urandom_range(0, 1023)); end
        default: begin w = 0; h = 1023; end
      endcase
      sa = (seg == 2) ? int'($urandom_range(0, 32767))
                      : int'($urandom_range(0, ANGLE_FULL - 1));
      write_reg(REG_BOX_WIDTH, CFG_DATA_W'(w));
      write_reg(REG_BOX_HEIGHT, CFG_DATA_W'(h));
      write_reg(REG_START_X, CFG_DATA_W'($urandom));
      write_reg(REG_START_Y, CFG_DATA_W'($urandom));
      write_reg(REG_START_ANGLE, CFG_DATA_W'(sa));
      if (seg == 2)
        write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  CFG_DATA_W'($urandom));
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        steady = ((n / 30) % 3 == 2);
        issue_request(1'($urandom_range(0, 7) == 0), rand_shift(), rand_shift(), rand_turn(),
                      1'b0, '0, '0);
        pace_sender(steady);
        // Pause the sender once until the block has drained
        if (seg == 1 && n == SEGMENT_ITEMS / 2) wait_quiet();
      end
    end

    wait_quiet();
    repeat (40) @(posedge clk);
    if (pending_corners.size() != 0) note_fault("corner never delivered",
                                                pending_corners[0], '0);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rbpc_pkg.sv
hdl/rbpc_cordic.sv
hdl/rotated_box_pose_corners_top.sv
sim/tb.sv
